FILE: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 9;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 3;
  localparam int STIME_W  = 16;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 32;

  localparam logic [KEY_W-1:0] PRIO_MAX = 9'd255;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ    = 2'd0,
    CMD_POP    = 2'd1,
    CMD_EXACT  = 2'd2,
    CMD_THRESH = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_NOMATCH = 3'd4
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN_RD  = 6'b000010,
    S_SCAN_CMP = 6'b000100,
    S_MOVE_RD  = 6'b001000,
    S_MOVE_WR  = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

endpackage

FILE: rtl/spq_cmp.sv
// Shared priority comparator: decides where the scan of the queue stops.
module spq_cmp (
  input  spq_pkg::cmd_t                  cmd,
  input  logic [spq_pkg::KEY_W-1:0]      key,
  input  logic [spq_pkg::PRIO_W-1:0]     prio,
  output logic                           stop
);

  logic [spq_pkg::KEY_W-1:0] prio_ext;

  assign prio_ext = spq_pkg::KEY_W'(prio);

  // Stop at the head for a pop, the insert point, the first exact hit, or the first entry at or above threshold
  always_comb begin
    unique case (cmd)
      spq_pkg::CMD_ENQ:    stop = (prio_ext > key);
      spq_pkg::CMD_POP:    stop = 1'b1;
      spq_pkg::CMD_EXACT:  stop = (prio_ext == key);
      spq_pkg::CMD_THRESH: stop = (prio_ext >= key);
      default:             stop = 1'b1;
    endcase
  end

endmodule

FILE: rtl/sorted_priority_queue.sv
// Sorted priority queue top level: command sequencer, entry memory and result register.
//
// Use: each word on the s_ channel is one command (enqueue, pop head, remove an
// exact priority, remove the last entry below a threshold). Each command gives
// exactly one result word on the m_ channel: a status and the removed entry.
// Entries live in a single-port-write, registered-read memory of CAPACITY
// words kept in ascending priority order; equal priorities stay first in,
// first out.
// Operation: one command is worked at a time. A command rejected up front
// (bad priority, full, empty) has its result word loaded without a scan.
// Otherwise one shared comparator scans the entries in order, then entries
// move one at a time through the memory, one memory access per step.
// s_tready is high only while the sequencer is idle.
// Stall: a finished result waits in the output register; the next command is
// accepted meanwhile, and its own result waits until the first is taken.
// Reset: rst empties the queue and drops any pending result; memory contents
// are not cleared, since only slots below the entry count are ever read.
module sorted_priority_queue #(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [1:0] cmd, [10:2] key, [26:11] service_time, [31:27] zero
  input  logic [spq_pkg::IN_W-1:0]      s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [2:0] status, [10:3] removed_priority, [26:11] removed_time, [31:27] zero
  output logic [spq_pkg::OUT_W-1:0]     m_tdata
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = (TIME_BITS < spq_pkg::STIME_W) ? TIME_BITS : spq_pkg::STIME_W;

  typedef struct packed {
    logic [spq_pkg::PRIO_W-1:0] prio;
    logic [TIME_BITS-1:0]       stime;
  } entry_t;

  spq_pkg::state_t              state;
  spq_pkg::cmd_t                cmd_r;
  logic [spq_pkg::KEY_W-1:0]    key_r;
  logic [TIME_BITS-1:0]         time_r;
  logic [CW-1:0]                count;
  logic [CW-1:0]                idx;
  logic [CW-1:0]                pos;
  entry_t                       hold;
  spq_pkg::status_t             res_status;
  logic [spq_pkg::PRIO_W-1:0]   res_prio;
  logic [TIME_BITS-1:0]         res_time;

  entry_t                       mem [CAPACITY];
  entry_t                       rd_data;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  entry_t                       wr_data;

  spq_pkg::cmd_t                in_cmd;
  logic [spq_pkg::KEY_W-1:0]    in_key;
  logic                         stop;
  logic                         ins_mode;
  logic                         move_end;
  logic                         out_free;

  assign in_cmd   = spq_pkg::cmd_t'(s_tdata[1:0]);
  assign in_key   = s_tdata[10:2];
  assign s_tready = (state == spq_pkg::S_IDLE);
  assign ins_mode = (cmd_r == spq_pkg::CMD_ENQ);
  assign out_free = !m_tvalid || m_tready;

  // Insert moves run down from the tail, removals close the gap upward
  assign move_end = ins_mode ? (idx == pos) : ((idx + CW'(1)) >= count);

  spq_cmp u_cmp (
    .cmd  (cmd_r),
    .key  (key_r),
    .prio (rd_data.prio),
    .stop (stop)
  );

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    unique case (state)
      spq_pkg::S_SCAN_RD: begin
        rd_en = (idx != count);
      end
      spq_pkg::S_MOVE_RD: begin
        if (move_end) begin
          wr_en         = ins_mode;
          wr_addr       = pos[AW-1:0];
          wr_data.prio  = key_r[spq_pkg::PRIO_W-1:0];
          wr_data.stime = time_r;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ins_mode ? AW'(idx - CW'(1)) : AW'(idx + CW'(1));
        end
      end
      spq_pkg::S_MOVE_WR: begin
        wr_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= spq_pkg::S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Drop the result word once taken, unless a new one loads now
      if (m_tvalid && m_tready && state != spq_pkg::S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        spq_pkg::S_IDLE: begin
          if (s_tvalid) begin
            cmd_r      <= in_cmd;
            key_r      <= in_key;
            time_r     <= TIME_BITS'(s_tdata[11 +: SW]);
            idx        <= '0;
            res_status <= spq_pkg::ST_OK;
            res_prio   <= '0;
            res_time   <= '0;
            if (in_cmd == spq_pkg::CMD_ENQ) begin
              if (in_key == '0 || in_key > spq_pkg::PRIO_MAX) begin
                res_status <= spq_pkg::ST_RANGE;
                state      <= spq_pkg::S_DONE;
              end else if (count == CW'(CAPACITY)) begin
                res_status <= spq_pkg::ST_FULL;
                state      <= spq_pkg::S_DONE;
              end else begin
                state <= spq_pkg::S_SCAN_RD;
              end
            end else if (count == '0) begin
              res_status <= spq_pkg::ST_EMPTY;
              state      <= spq_pkg::S_DONE;
            end else begin
              state <= spq_pkg::S_SCAN_RD;
            end
          end
        end

        spq_pkg::S_SCAN_RD: begin
          if (idx == count) begin
            // Scan ran off the tail
            unique case (cmd_r)
              spq_pkg::CMD_ENQ: begin
                pos   <= count;
                state <= spq_pkg::S_MOVE_RD;
              end
              spq_pkg::CMD_THRESH: begin
                pos      <= count - CW'(1);
                idx      <= count - CW'(1);
                res_prio <= hold.prio;
                res_time <= hold.stime;
                state    <= spq_pkg::S_MOVE_RD;
              end
              default: begin
                res_status <= spq_pkg::ST_NOMATCH;
                state      <= spq_pkg::S_DONE;
              end
            endcase
          end else begin
            state <= spq_pkg::S_SCAN_CMP;
          end
        end

        spq_pkg::S_SCAN_CMP: begin
          if (stop) begin
            unique case (cmd_r)
              spq_pkg::CMD_ENQ: begin
                pos   <= idx;
                idx   <= count;
                state <= spq_pkg::S_MOVE_RD;
              end
              spq_pkg::CMD_THRESH: begin
                if (idx == '0) begin
                  res_status <= spq_pkg::ST_NOMATCH;
                  state      <= spq_pkg::S_DONE;
                end else begin
                  pos      <= idx - CW'(1);
                  idx      <= idx - CW'(1);
                  res_prio <= hold.prio;
                  res_time <= hold.stime;
                  state    <= spq_pkg::S_MOVE_RD;
                end
              end
              default: begin
                pos      <= idx;
                res_prio <= rd_data.prio;
                res_time <= rd_data.stime;
                state    <= spq_pkg::S_MOVE_RD;
              end
            endcase
          end else begin
            hold  <= rd_data;
            idx   <= idx + CW'(1);
            state <= spq_pkg::S_SCAN_RD;
          end
        end

        spq_pkg::S_MOVE_RD: begin
          if (move_end) begin
            count <= ins_mode ? (count + CW'(1)) : (count - CW'(1));
            state <= spq_pkg::S_DONE;
          end else begin
            state <= spq_pkg::S_MOVE_WR;
          end
        end

        spq_pkg::S_MOVE_WR: begin
          idx   <= ins_mode ? (idx - CW'(1)) : (idx + CW'(1));
          state <= spq_pkg::S_MOVE_RD;
        end

        spq_pkg::S_DONE: begin
          // Load the result word once the output register is free
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, spq_pkg::STIME_W'(res_time[SW-1:0]), res_prio, res_status};
            state    <= spq_pkg::S_IDLE;
          end
        end

        default: begin
          state <= spq_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Entry count never exceeds the memory depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (count == $past(count) || count == $past(count) + CW'(1) ||
              count + CW'(1) == $past(count)))
    else $error("entry count jumped");

  // An accepted command keeps the sequencer busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sequencer idle right after accept");

  // A failed command reports no removed entry
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != spq_pkg::ST_OK |-> m_tdata[26:3] == '0)
    else $error("failed command reports an entry");

endmodule

FILE: test/spq_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted priority queue: mirrors the queue contents and compares result words.
module spq_checker #(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  // [1:0] cmd, [10:2] key, [26:11] service_time, [31:27] zero
  input  logic [spq_pkg::IN_W-1:0]  s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  // [2:0] status, [10:3] removed_priority, [26:11] removed_time, [31:27] zero
  input  logic [spq_pkg::OUT_W-1:0] m_tdata,
  output int                        fail_count,
  output int                        outstanding,
  output int                        checked_count,
  output int                        range_hits,
  output int                        full_hits,
  output int                        empty_hits,
  output int                        nomatch_hits
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    spq_pkg::status_t             status;
    logic [spq_pkg::PRIO_W-1:0]   prio;
    logic [spq_pkg::STIME_W-1:0]  stime;
  } queue_result_t;

  // Mirror of the queue, head at slot 0
  logic [spq_pkg::PRIO_W-1:0]  entry_prio  [CAPACITY];
  logic [spq_pkg::STIME_W-1:0] entry_stime [CAPACITY];
  int unsigned                 entry_total = 0;
  queue_result_t               awaited_results [$];

  int mismatches = 0;
  int checked    = 0;
  int n_range    = 0;
  int n_full     = 0;
  int n_empty    = 0;
  int n_nomatch  = 0;
  int n_waiting  = 0;

  assign fail_count    = mismatches;
  assign outstanding   = n_waiting;
  assign checked_count = checked;
  assign range_hits    = n_range;
  assign full_hits     = n_full;
  assign empty_hits    = n_empty;
  assign nomatch_hits  = n_nomatch;

  // Take out the entry at pos and close the gap behind it
  task automatic take_entry(input int unsigned pos, output queue_result_t res);
    res.status = spq_pkg::ST_OK;
    res.prio   = entry_prio[pos];
    res.stime  = entry_stime[pos];
    for (int unsigned i = pos; i + 1 < entry_total; i++) begin
      entry_prio[i]  = entry_prio[i + 1];
      entry_stime[i] = entry_stime[i + 1];
    end
    entry_total--;
  endtask

  // Apply one command to the mirror and work out its result word
  task automatic serve_command(input spq_pkg::cmd_t cmd,
                               input logic [spq_pkg::KEY_W-1:0] key,
                               input logic [spq_pkg::STIME_W-1:0] stime,
                               output queue_result_t res);
    int unsigned pos;
    logic [31:0] tmask;
    tmask      = (TIME_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TIME_BITS) - 32'd1);
    res.status = spq_pkg::ST_OK;
    res.prio   = '0;
    res.stime  = '0;
    if (cmd == spq_pkg::CMD_ENQ) begin
      if (key < 1 || key > spq_pkg::PRIO_MAX) begin
        res.status = spq_pkg::ST_RANGE;
      end else if (entry_total >= CAPACITY) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        // Insert behind every entry of equal or lower number
        pos = 0;
        while (pos < entry_total && {1'b0, entry_prio[pos]} <= key) pos++;
        for (int unsigned i = entry_total; i > pos; i--) begin
          entry_prio[i]  = entry_prio[i - 1];
          entry_stime[i] = entry_stime[i - 1];
        end
        entry_prio[pos]  = key[spq_pkg::PRIO_W-1:0];
        entry_stime[pos] = stime & tmask[spq_pkg::STIME_W-1:0];
        entry_total++;
      end
    end else if (entry_total == 0) begin
      res.status = spq_pkg::ST_EMPTY;
    end else begin
      case (cmd)
        spq_pkg::CMD_POP: begin
          take_entry(0, res);
        end
        spq_pkg::CMD_EXACT: begin
          pos = 0;
          while (pos < entry_total && {1'b0, entry_prio[pos]} != key) pos++;
          if (pos == entry_total) res.status = spq_pkg::ST_NOMATCH;
          else take_entry(pos, res);
        end
        default: begin
          // Last entry strictly below the threshold
          pos = 0;
          while (pos < entry_total && {1'b0, entry_prio[pos]} < key) pos++;
          if (pos == 0) res.status = spq_pkg::ST_NOMATCH;
          else take_entry(pos - 1, res);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin : watch
    queue_result_t want;
    queue_result_t got;
    queue_result_t predicted;
    if (rst) begin
      entry_total = 0;
      awaited_results.delete();
    end else begin
      // Compare an accepted result word with the oldest prediction
      if (m_tvalid && m_tready) begin
        got.status = spq_pkg::status_t'(m_tdata[spq_pkg::STATUS_W-1:0]);
        got.prio   = m_tdata[spq_pkg::STATUS_W +: spq_pkg::PRIO_W];
        got.stime  = m_tdata[spq_pkg::STATUS_W+spq_pkg::PRIO_W +: spq_pkg::STIME_W];
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected result word %h: status %0d prio %0d time %h",
                     $realtime, m_tdata, got.status, got.prio, got.stime);
        end else begin
          want = awaited_results.pop_front();
          checked++;
          case (want.status)
            spq_pkg::ST_RANGE:   n_range++;
            spq_pkg::ST_FULL:    n_full++;
            spq_pkg::ST_EMPTY:   n_empty++;
            spq_pkg::ST_NOMATCH: n_nomatch++;
            default: ;
          endcase
          if (got.status !== want.status || got.prio !== want.prio ||
              got.stime !== want.stime) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"[%0t] result %0d: expected status %0d prio %0d time %h, ",
                        "got status %0d prio %0d time %h"},
                       $realtime, checked, want.status, want.prio, want.stime,
                       got.status, got.prio, got.stime);
          end
        end
      end
      // Predict the result of an accepted command word
      if (s_tvalid && s_tready) begin
        serve_command(spq_pkg::cmd_t'(s_tdata[spq_pkg::CMD_W-1:0]),
                      s_tdata[spq_pkg::CMD_W +: spq_pkg::KEY_W],
                      s_tdata[spq_pkg::CMD_W+spq_pkg::KEY_W +: spq_pkg::STIME_W],
                      predicted);
        awaited_results.push_back(predicted);
      end
    end
    n_waiting = awaited_results.size();
  end

endmodule

FILE: test/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps
// Testbench top for the sorted priority queue: clock, reset, command stimulus and verdict.
module tb_sorted_priority_queue;

  localparam int CAPACITY     = 16;
  localparam int TIME_BITS    = 16;
  localparam int RANDOM_ITEMS = 930;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PAD_W        = spq_pkg::IN_W - spq_pkg::CMD_W - spq_pkg::KEY_W -
                                spq_pkg::STIME_W;

  logic                      clk      = 1'b0;
  logic                      rst      = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic [spq_pkg::IN_W-1:0]  s_tdata  = '0;
  logic                      m_tready = 1'b0;
  logic                      s_tready;
  logic                      m_tvalid;
  logic [spq_pkg::OUT_W-1:0] m_tdata;

  int cycles     = 0;
  int burst_left = 0;
  int words_sent = 0;

  int fail_count;
  int outstanding;
  int checked_count;
  int range_hits;
  int full_hits;
  int empty_hits;
  int nomatch_hits;

  sorted_priority_queue #(
    .CAPACITY (CAPACITY),
    .TIME_BITS(TIME_BITS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  spq_checker #(
    .CAPACITY (CAPACITY),
    .TIME_BITS(TIME_BITS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .checked_count(checked_count),
    .range_hits   (range_hits),
    .full_hits    (full_hits),
    .empty_hits   (empty_hits),
    .nomatch_hits (nomatch_hits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stall the result channel: always ready, light, heavy and periodic stretches
  always @(posedge clk) begin
    case ((cycles / 97) % 4)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 3) != 0);
      2:       m_tready <= ($urandom_range(0, 7) == 0);
      default: m_tready <= ((cycles % 5) < 2);
    endcase
  end

  // Offer one command word, hold until accepted, then maybe idle at the end of a burst
  task automatic send_cmd(input spq_pkg::cmd_t cmd, input logic [spq_pkg::KEY_W-1:0] key,
                          input logic [spq_pkg::STIME_W-1:0] stime);
    int idle;
    s_tdata  <= {{PAD_W{1'b0}}, stime, key, cmd};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (idle > 0) begin
        s_tvalid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
  endtask

  // Priority key: often a narrow band for duplicates, sometimes out of range
  function automatic logic [spq_pkg::KEY_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      return spq_pkg::KEY_W'($urandom_range(1, 8));
    else if (r < 80) return spq_pkg::KEY_W'($urandom_range(1, 255));
    else if (r < 88) return (r < 84) ? spq_pkg::KEY_W'(1) : spq_pkg::KEY_W'(255);
    else if (r < 94) return '0;
    else             return spq_pkg::KEY_W'($urandom_range(256, 511));
  endfunction

  initial begin
    int phase;
    int enq_share;
    int r;
    phase = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Removals on an empty queue
    send_cmd(spq_pkg::CMD_POP,    9'd0,   16'h0000);
    send_cmd(spq_pkg::CMD_EXACT,  9'd5,   16'h0000);
    send_cmd(spq_pkg::CMD_THRESH, 9'd511, 16'hFFFF);
    // Bad priorities
    send_cmd(spq_pkg::CMD_ENQ,    9'd0,   16'h1234);
    send_cmd(spq_pkg::CMD_ENQ,    9'd256, 16'h1234);
    send_cmd(spq_pkg::CMD_ENQ,    9'd511, 16'hFFFF);
    // Extremes and equal priorities in arrival order
    send_cmd(spq_pkg::CMD_ENQ,    9'd255, 16'hFFFF);
    send_cmd(spq_pkg::CMD_ENQ,    9'd1,   16'h0000);
    send_cmd(spq_pkg::CMD_ENQ,    9'd5,   16'h1111);
    send_cmd(spq_pkg::CMD_ENQ,    9'd5,   16'h2222);
    send_cmd(spq_pkg::CMD_ENQ,    9'd5,   16'h3333);
    // Threshold at or below the head, exact keys that cannot match
    send_cmd(spq_pkg::CMD_THRESH, 9'd1,   16'h0000);
    send_cmd(spq_pkg::CMD_THRESH, 9'd0,   16'h0000);
    send_cmd(spq_pkg::CMD_EXACT,  9'd0,   16'h0000);
    send_cmd(spq_pkg::CMD_EXACT,  9'd300, 16'h0000);
    send_cmd(spq_pkg::CMD_EXACT,  9'd7,   16'h0000);
    // Matching removals, threshold above 255 takes the tail
    send_cmd(spq_pkg::CMD_EXACT,  9'd5,   16'h0000);
    send_cmd(spq_pkg::CMD_THRESH, 9'd6,   16'h0000);
    send_cmd(spq_pkg::CMD_THRESH, 9'd511, 16'h0000);
    send_cmd(spq_pkg::CMD_POP,    9'd511, 16'hFFFF);
    send_cmd(spq_pkg::CMD_POP,    9'd0,   16'h0000);
    send_cmd(spq_pkg::CMD_POP,    9'd0,   16'h0000);
    // Threshold removal of a single entry
    send_cmd(spq_pkg::CMD_ENQ,    9'd128, 16'hA5A5);
    send_cmd(spq_pkg::CMD_THRESH, 9'd200, 16'h5A5A);
    send_cmd(spq_pkg::CMD_THRESH, 9'd200, 16'h0000);

    // Random phases that fill, drain or churn the queue
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) phase = $urandom_range(0, 2);
      enq_share = (phase == 0) ? 75 : (phase == 1) ? 20 : 50;
      if ($urandom_range(0, 99) < enq_share) begin
        send_cmd(spq_pkg::CMD_ENQ, pick_prio(), spq_pkg::STIME_W'($urandom));
      end else begin
        r = $urandom_range(0, 2);
        case (r)
          0: send_cmd(spq_pkg::CMD_POP, spq_pkg::KEY_W'($urandom_range(0, 511)),
                      spq_pkg::STIME_W'($urandom));
          1: send_cmd(spq_pkg::CMD_EXACT, pick_prio(), spq_pkg::STIME_W'($urandom));
          default: begin
            r = $urandom_range(0, 9);
            if (r < 6)       send_cmd(spq_pkg::CMD_THRESH,
                                      spq_pkg::KEY_W'($urandom_range(1, 10)),
                                      spq_pkg::STIME_W'($urandom));
            else if (r < 8)  send_cmd(spq_pkg::CMD_THRESH,
                                      spq_pkg::KEY_W'($urandom_range(0, 255)),
                                      spq_pkg::STIME_W'($urandom));
            else             send_cmd(spq_pkg::CMD_THRESH,
                                      spq_pkg::KEY_W'($urandom_range(256, 511)),
                                      spq_pkg::STIME_W'($urandom));
          end
        endcase
      end
    end
    s_tvalid <= 1'b0;

    // Drain the remaining results, then watch for strays
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands, checked %0d results in %0d cycles.",
             words_sent, checked_count, cycles);
    $display("Statuses seen: %0d bad priority, %0d full, %0d empty, %0d no match.",
             range_hits, full_hits, empty_hits, nomatch_hits);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/spq_pkg.sv
rtl/spq_cmp.sv
rtl/sorted_priority_queue.sv
test/spq_checker.sv
test/tb_sorted_priority_queue.sv
